// ===== rtl/bdpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

   localparam int NUM_BUTTONS = 5;
   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int MODES_WIDTH = 2 * NUM_BUTTONS;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
   localparam int CSR_DATA_WIDTH = (MODES_WIDTH > CFG_WIDTH) ? MODES_WIDTH : CFG_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TICKS  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_TICKS      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERY_LONG_TICKS = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BUTTON_MODES    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESSED_LEVEL   = 3'd4;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TICKS_RESET  = 16'd20;
   localparam logic [CFG_WIDTH-1:0] LONG_TICKS_RESET      = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] VERY_LONG_TICKS_RESET = 16'd3000;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_TICK   = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      MODE_NONE       = 2'd0,
      MODE_ON_RELEASE = 2'd1,
      MODE_RISE_ONCE  = 2'd2,
      MODE_REPEAT     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ACT_NONE      = 2'd0,
      ACT_SHORT     = 2'd1,
      ACT_LONG      = 2'd2,
      ACT_VERY_LONG = 2'd3
   } action_type;

   typedef struct packed {
      func_type               func;
      logic [NUM_BUTTONS-1:0] pin_levels;
   } req_payload_type;

   typedef struct packed {
      logic [MODES_WIDTH-1:0] actions;
      logic [NUM_BUTTONS-1:0] debounced_pressed;
   } rsp_payload_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0]   debounce_ticks;
      logic [CFG_WIDTH-1:0]   long_press_ticks;
      logic [CFG_WIDTH-1:0]   very_long_press_ticks;
      logic [MODES_WIDTH-1:0] button_modes;
      logic                   pressed_level;
   } cfg_type;

   typedef struct packed {
      action_type action;
      logic       pressed;
   } lane_status_type;

endpackage

// ===== rtl/bdpc_lane.sv =====
// ----------------------------------------------------------------------------
// bdpc_lane
// One button: debounce machine, debounce and press counters, classifier.
// ----------------------------------------------------------------------------
module bdpc_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  bdpc_pkg::func_type        func,
   input  logic                      pin,
   input  bdpc_pkg::mode_type        mode,
   input  bdpc_pkg::cfg_type         cfg,
   output bdpc_pkg::lane_status_type status
);
   import bdpc_pkg::*;

   typedef enum logic [1:0] {
      ST_STARTUP  = 2'd0,
      ST_RELEASED = 2'd1,
      ST_WAIT     = 2'd2,
      ST_PRESSED  = 2'd3
   } dstate_type;

   dstate_type             dstate_ff, dstate_in;
   logic [CFG_WIDTH-1:0]   dcount_ff, dcount_in;
   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] pcount_ff, pcount_in;
   action_type             action_ff, action_in;

   logic                 down;
   logic [CMP_WIDTH-1:0] cnt_ext;
   logic                 ge_long, ge_very_long;
   logic [1:0]           rise_phase;

   assign down         = (pin == cfg.pressed_level);
   assign cnt_ext      = CMP_WIDTH'(pcount_ff);
   assign ge_long      = (cnt_ext >= CMP_WIDTH'(cfg.long_press_ticks));
   assign ge_very_long = (cnt_ext >= CMP_WIDTH'(cfg.very_long_press_ticks));
   // release drops the phase before the rise-once thresholds are checked
   assign rise_phase   = (dstate_in == ST_RELEASED) ? 2'd0 : phase_ff;

   always_comb begin
      dstate_in = dstate_ff;
      dcount_in = dcount_ff;
      phase_in  = phase_ff;
      pcount_in = pcount_ff;
      action_in = action_ff;
      unique case (func)
         FUNC_SAMPLE: begin
            unique case (dstate_ff)
               ST_STARTUP: begin
                  if (!down) dstate_in = ST_RELEASED;
               end
               ST_RELEASED: begin
                  if (down) begin
                     dstate_in = ST_WAIT;
                     dcount_in = '0;
                  end
               end
               ST_WAIT: begin
                  if (dcount_ff >= cfg.debounce_ticks)
                     dstate_in = down ? ST_PRESSED : ST_RELEASED;
               end
               ST_PRESSED: begin
                  if (!down) begin
                     dstate_in = ST_WAIT;
                     dcount_in = '0;
                  end
               end
            endcase
            // classifier sees the updated debounce state
            if (action_ff == ACT_NONE) begin
               if (phase_ff == 2'd0) begin
                  if (dstate_in == ST_PRESSED) phase_in = 2'd1;
               end else begin
                  unique case (mode)
                     MODE_NONE: begin
                     end
                     MODE_ON_RELEASE: begin
                        if (dstate_in == ST_RELEASED) begin
                           phase_in = 2'd0;
                           priority if (ge_very_long) action_in = ACT_VERY_LONG;
                           else if (ge_long)          action_in = ACT_LONG;
                           else                       action_in = ACT_SHORT;
                        end
                     end
                     MODE_RISE_ONCE: begin
                        phase_in = rise_phase;
                        priority if (ge_very_long && rise_phase == 2'd3) begin
                           action_in = ACT_VERY_LONG;
                           phase_in  = 2'd1;
                        end else if (ge_long && rise_phase == 2'd2) begin
                           action_in = ACT_LONG;
                           phase_in  = 2'd3;
                        end else if (!ge_long && rise_phase == 2'd1) begin
                           action_in = ACT_SHORT;
                           phase_in  = 2'd2;
                        end else begin
                        end
                     end
                     MODE_REPEAT: begin
                        phase_in  = 2'd0;
                        action_in = ACT_SHORT;
                     end
                  endcase
               end
            end
         end
         FUNC_TICK: begin
            if (dcount_ff < cfg.debounce_ticks) dcount_in = dcount_ff + 1'b1;
            if (phase_ff != 2'd0) begin
               if (!(&pcount_ff)) pcount_in = pcount_ff + 1'b1;
            end else begin
               pcount_in = '0;
            end
         end
         FUNC_CLEAR: begin
            action_in = ACT_NONE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dstate_ff <= ST_STARTUP;
         dcount_ff <= '0;
         phase_ff  <= 2'd0;
         pcount_ff <= '0;
         action_ff <= ACT_NONE;
      end else if (accept) begin
         dstate_ff <= dstate_in;
         dcount_ff <= dcount_in;
         phase_ff  <= phase_in;
         pcount_ff <= pcount_in;
         action_ff <= action_in;
      end
   end

   assign status.action  = action_in;
   assign status.pressed = (dstate_in == ST_PRESSED);

endmodule

// ===== rtl/bdpc_merge.sv =====
// ----------------------------------------------------------------------------
// bdpc_merge
// Packs the lane results into one response and holds it in an output
// register backed by a skid stage.
// ----------------------------------------------------------------------------
module bdpc_merge (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               push,
   input  bdpc_pkg::lane_status_type [bdpc_pkg::NUM_BUTTONS-1:0] lanes,
   output logic                                               req_ready,
   output logic                                               rsp_valid,
   input  logic                                               rsp_ready,
   output bdpc_pkg::rsp_payload_type                          rsp_data
);
   import bdpc_pkg::*;

   rsp_payload_type packed_rsp;
   rsp_payload_type out_data_ff, out_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;

   always_comb begin
      packed_rsp = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         packed_rsp.actions[2*i +: 2]    = lanes[i].action;
         packed_rsp.debounced_pressed[i] = lanes[i].pressed;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_ready) begin
         // output slot frees up: the older transaction goes first
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = packed_rsp;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = packed_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_ready = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/button_debounce_press_classifier_top.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_top
// Debounces five buttons and classifies presses as short, long or very long.
// Every request gives exactly one response that reports the latched actions
// and the debounced pressed state after the request took effect. A request
// is taken every clock cycle unless the skid stage is full, and its response
// is registered; each button has its own lane, so the rate is one request
// per cycle while the skid stage holds no waiting response. A two-deep output
// (response register plus skid stage) keeps requests flowing while one
// response waits. Tick requests advance the debounce and press counters,
// sample requests run the debounce machines and classifiers, clear requests
// drop the latched actions. The csr port always accepts writes; registers
// must be written only while no request is in flight.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  bdpc_pkg::req_payload_type               req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output bdpc_pkg::rsp_payload_type               rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [bdpc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bdpc_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import bdpc_pkg::*;

   cfg_type                             cfg_ff, cfg_in;
   logic                                accept;
   lane_status_type [NUM_BUTTONS-1:0]   lanes;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TICKS:  cfg_in.debounce_ticks        = csr_data[CFG_WIDTH-1:0];
            CSR_LONG_TICKS:      cfg_in.long_press_ticks      = csr_data[CFG_WIDTH-1:0];
            CSR_VERY_LONG_TICKS: cfg_in.very_long_press_ticks = csr_data[CFG_WIDTH-1:0];
            CSR_BUTTON_MODES:    cfg_in.button_modes          = csr_data[MODES_WIDTH-1:0];
            CSR_PRESSED_LEVEL:   cfg_in.pressed_level         = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks        <= DEBOUNCE_TICKS_RESET;
         cfg_ff.long_press_ticks      <= LONG_TICKS_RESET;
         cfg_ff.very_long_press_ticks <= VERY_LONG_TICKS_RESET;
         cfg_ff.button_modes          <= '0;
         cfg_ff.pressed_level         <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      bdpc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (accept),
         .func   (req_data.func),
         .pin    (req_data.pin_levels[i]),
         .mode   (mode_type'(cfg_ff.button_modes[2*i +: 2])),
         .cfg    (cfg_ff),
         .status (lanes[i])
      );
   end

   bdpc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .lanes     (lanes),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // every accepted transaction has a response waiting the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request left no response");

   // back-pressure on requests only while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // reset empties the output and skid stages
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output stages not empty after reset");

endmodule
